// File: rtl/core/crs_pkg.sv
package crs_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W = 4;

  localparam logic [COORD_W-1:0] SURF_W_RST = 16'd320;
  localparam logic [COORD_W-1:0] SURF_H_RST = 16'd240;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_H = 1'd1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
  } rect_t;

  typedef struct packed {
    status_t          status;
    logic             push_emitted;
    logic [CNT_W-1:0] pop_count;
    rect_t            clip;
    logic [CNT_W-1:0] depth;
    logic             pass_open;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted word, start the stack read
    logic commit;  // apply the operation and load the result register
  } ctrl_cmd_t;

endpackage

// File: rtl/core/crs_if.sv
interface crs_in_if;
  import crs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic [COORD_W-1:0]        rect_w;
  logic [COORD_W-1:0]        rect_h;

  modport source (output valid, output operation, output rect_x, output rect_y,
                  output rect_w, output rect_h, input ready);
  modport sink (input valid, input operation, input rect_x, input rect_y,
                input rect_w, input rect_h, output ready);
endinterface

interface crs_out_if;
  import crs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic                      push_emitted;
  logic [CNT_W-1:0]          pop_count;
  logic signed [COORD_W-1:0] clip_x;
  logic signed [COORD_W-1:0] clip_y;
  logic [COORD_W-1:0]        clip_w;
  logic [COORD_W-1:0]        clip_h;
  logic [CNT_W-1:0]          depth;
  logic                      pass_open;

  modport source (output valid, output status, output push_emitted, output pop_count,
                  output clip_x, output clip_y, output clip_w, output clip_h,
                  output depth, output pass_open, input ready);
  modport sink (input valid, input status, input push_emitted, input pop_count,
                input clip_x, input clip_y, input clip_w, input clip_h,
                input depth, input pass_open, output ready);
endinterface

// File: rtl/core/crs_ctrl.sv
module crs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output crs_pkg::ctrl_cmd_t cmd
);
  import crs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
          if (out_ready) out_valid_r <= 1'b0;
        end
        S_EXEC: begin
          // wait here until the result register can take the new word
          if (out_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result register not valid after commit");

endmodule

// File: rtl/core/crs_dp.sv
module crs_dp #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crs_pkg::ctrl_cmd_t               cmd,
  input  logic                             cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [1:0]                       in_operation,
  input  logic signed [crs_pkg::COORD_W-1:0] in_rect_x,
  input  logic signed [crs_pkg::COORD_W-1:0] in_rect_y,
  input  logic [crs_pkg::COORD_W-1:0]      in_rect_w,
  input  logic [crs_pkg::COORD_W-1:0]      in_rect_h,
  output crs_pkg::result_t                 res
);
  import crs_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(STACK_DEPTH);

  // configuration
  logic [COORD_W-1:0] surf_w_r;
  logic [COORD_W-1:0] surf_h_r;

  // architectural state
  rect_t             cur_r, cur_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic              active_r, active_nxt;

  // latched word and stack read data
  op_t               op_r;
  rect_t             req_r;
  rect_t             rd_data_r;
  rect_t             stack_mem [STACK_DEPTH];
  logic [LVL_W-1:0]  rd_lvl;

  result_t           res_r;

  // intersection
  logic signed [COORD_W+1:0] ax1, ay1, bx1, by1, ax2, ay2, bx2, by2;
  logic signed [COORD_W+1:0] x1, y1, x2, y2, dx, dy;
  logic                      any_zero;
  rect_t                     isect;
  rect_t                     surf;

  status_t           st;
  logic              pushed;
  logic [LVL_W-1:0]  pops;
  logic [LVL_W+CNT_W-1:0] pops_ext, lvl_ext;

  assign rd_lvl = level_r - LVL_W'(1);

  always_comb begin
    ax1 = {{2{cur_r.x[COORD_W-1]}}, cur_r.x};
    ay1 = {{2{cur_r.y[COORD_W-1]}}, cur_r.y};
    bx1 = {{2{req_r.x[COORD_W-1]}}, req_r.x};
    by1 = {{2{req_r.y[COORD_W-1]}}, req_r.y};
    ax2 = ax1 + $signed({2'b00, cur_r.w});
    ay2 = ay1 + $signed({2'b00, cur_r.h});
    bx2 = bx1 + $signed({2'b00, req_r.w});
    by2 = by1 + $signed({2'b00, req_r.h});
    x1  = (ax1 > bx1) ? ax1 : bx1;
    y1  = (ay1 > by1) ? ay1 : by1;
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    dx  = x2 - x1;
    dy  = y2 - y1;
    any_zero = (cur_r.w == '0) || (cur_r.h == '0) || (req_r.w == '0) || (req_r.h == '0);
    isect = '0;
    if (!any_zero && (x2 > x1) && (y2 > y1)) begin
      isect.x = x1[COORD_W-1:0];
      isect.y = y1[COORD_W-1:0];
      isect.w = dx[COORD_W-1:0];
      isect.h = dy[COORD_W-1:0];
    end
  end

  always_comb begin
    surf.x = '0;
    surf.y = '0;
    surf.w = surf_w_r;
    surf.h = surf_h_r;
  end

  // operation decode
  always_comb begin
    cur_nxt    = cur_r;
    level_nxt  = level_r;
    active_nxt = active_r;
    st         = ST_OK;
    pushed     = 1'b0;
    pops       = '0;
    priority if (op_r == OP_BEGIN) begin
      cur_nxt    = surf;
      level_nxt  = '0;
      active_nxt = 1'b1;
    end else if (!active_r) begin
      st = ST_INACTIVE;
    end else if (op_r == OP_END) begin
      pops       = level_r;
      level_nxt  = '0;
      cur_nxt    = surf;
      active_nxt = 1'b0;
    end else if (op_r == OP_PUSH) begin
      if (level_r >= LVL_MAX) begin
        st = ST_FULL;
      end else begin
        cur_nxt   = isect;
        level_nxt = level_r + LVL_W'(1);
        pushed    = 1'b1;
      end
    end else begin
      if (level_r != '0) begin
        level_nxt = rd_lvl;
        cur_nxt   = rd_data_r;
        pops      = LVL_W'(1);
      end else begin
        level_nxt = '0;
        cur_nxt   = surf;
      end
    end
  end

  assign pops_ext = {{CNT_W{1'b0}}, pops};
  assign lvl_ext  = {{CNT_W{1'b0}}, level_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= SURF_W_RST;
      surf_h_r <= SURF_H_RST;
      cur_r    <= '0;
      level_r  <= '0;
      active_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SURF_W: surf_w_r <= cfg_wdata;
          CFG_SURF_H: surf_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        cur_r    <= cur_nxt;
        level_r  <= level_nxt;
        active_r <= active_nxt;
      end
    end
  end

  // word latch, stack read and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      req_r.x <= in_rect_x;
      req_r.y <= in_rect_y;
      req_r.w <= in_rect_w;
      req_r.h <= in_rect_h;
      if (level_r != '0) rd_data_r <= stack_mem[rd_lvl[IDX_W-1:0]];
    end
    if (cmd.commit) begin
      if (pushed) stack_mem[level_r[IDX_W-1:0]] <= cur_r;
      res_r.status       <= st;
      res_r.push_emitted <= pushed;
      res_r.pop_count    <= pops_ext[CNT_W-1:0];
      res_r.clip         <= cur_nxt;
      res_r.depth        <= lvl_ext[CNT_W-1:0];
      res_r.pass_open    <= active_nxt;
    end
  end

  assign res = res_r;

  ap_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_MAX)
    else $error("nesting level beyond stack depth");

  ap_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> level_r == '0)
    else $error("stack not empty outside a pass");

  ap_push_rises: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && pushed |=> level_r == $past(level_r) + LVL_W'(1))
    else $error("push did not raise the level");

endmodule

// File: rtl/core/clip_rect_stack.sv
// channel   | dir | handshake      | carries
// in_word   | in  | valid / ready  | operation, rect_x, rect_y, rect_w, rect_h
// out_word  | out | valid / ready  | status, push_emitted, pop_count, clip, depth, pass_open
// cfg_*     | in  | cfg_we only    | cfg_index selects width (0) or height (1), cfg_wdata
//
// each word is accepted (stack read issued), then executed into the
// result register; the registered stack read port is why execute is a state of its own
// a new word is accepted while the previous result still waits in the output register
// execute stalls while the output register is full and out_word.ready is low
// synchronous active-low reset: no pass, empty stack, zero clip, surface 320 x 240
module clip_rect_stack #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  crs_in_if.sink                         in_word,
  crs_out_if.source                      out_word,
  input  logic                           cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import crs_pkg::*;

  ctrl_cmd_t cmd;
  result_t   res;

  // sequencing and output register valid
  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .cmd       (cmd)
  );

  // clip state, saved clip stack, intersection and result register
  crs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_word.operation),
    .in_rect_x    (in_word.rect_x),
    .in_rect_y    (in_word.rect_y),
    .in_rect_w    (in_word.rect_w),
    .in_rect_h    (in_word.rect_h),
    .res          (res)
  );

  assign out_word.status       = res.status;
  assign out_word.push_emitted = res.push_emitted;
  assign out_word.pop_count    = res.pop_count;
  assign out_word.clip_x       = res.clip.x;
  assign out_word.clip_y       = res.clip.y;
  assign out_word.clip_w       = res.clip.w;
  assign out_word.clip_h       = res.clip.h;
  assign out_word.depth        = res.depth;
  assign out_word.pass_open    = res.pass_open;

endmodule

// File: bench/tb.sv
module tb;
  import crs_pkg::*;

  localparam int NEST_MAX  = 8;       // stack depth the block is built with
  localparam int IDLE_MAX  = 13;      // longest per-word gap on either side
  localparam int HOLD_LEN  = 200;     // long receiver hold-off, in cycles
  localparam int CYCLE_CAP = 400000;  // far above the slowest correct run
  localparam int SHOW_MAX  = 50;      // mismatch lines printed before going quiet
  localparam int PHASES    = 8;

  // one operation word as the sender holds it
  typedef struct packed {
    op_t   op;
    rect_t rect;
  } clip_word_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SURF_W;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  crs_in_if  in_bus ();
  crs_out_if out_bus ();

  clip_rect_stack #(.STACK_DEPTH(NEST_MAX)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_bus),
    .out_word  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // clip stack predictor: own copy of surface size, current clip and saved clips
  // ---------------------------------------------------------------------------
  logic [15:0] surf_w = SURF_W_RST;
  logic [15:0] surf_h = SURF_H_RST;
  rect_t       live_clip = '0;
  rect_t       saved_clip [NEST_MAX];
  int          nest_level = 0;
  bit          pass_live = 1'b0;

  result_t     pending_reports [$];   // predicted result words, oldest first
  clip_word_t  op_words [$];          // words waiting to be offered

  // a few tallies for the closing summary
  int deepest = 0;
  int full_refusals = 0;
  int inactive_replies = 0;
  int empty_clips = 0;

  function automatic rect_t surface_clip();
    rect_t r;
    r = '0;
    r.w = surf_w;
    r.h = surf_h;
    return r;
  endfunction

  function automatic rect_t mk_rect(int x, int y, int w, int h);
    rect_t r;
    r.x = x[15:0];
    r.y = y[15:0];
    r.w = w[15:0];
    r.h = h[15:0];
    return r;
  endfunction

  // intersection in 32-bit signed space, empty or degenerate gives zero rectangle
  function automatic rect_t overlap(rect_t a, rect_t b);
    rect_t r;
    int    ax, ay, bx, by, lft, top, rgt, bot;
    r = '0;
    if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0)
      return r;
    ax  = {{16{a.x[15]}}, a.x};
    ay  = {{16{a.y[15]}}, a.y};
    bx  = {{16{b.x[15]}}, b.x};
    by  = {{16{b.y[15]}}, b.y};
    lft = (ax > bx) ? ax : bx;
    top = (ay > by) ? ay : by;
    rgt = (ax + int'(a.w) < bx + int'(b.w)) ? ax + int'(a.w) : bx + int'(b.w);
    bot = (ay + int'(a.h) < by + int'(b.h)) ? ay + int'(a.h) : by + int'(b.h);
    if (rgt <= lft || bot <= top)
      return r;
    r.x = lft[15:0];
    r.y = top[15:0];
    r.w = 16'(rgt - lft);
    r.h = 16'(bot - top);
    return r;
  endfunction

  // apply one accepted word to the predicted state, queue the result it owes
  task automatic predict_clip_op(input clip_word_t wd);
    result_t res;
    res = '0;
    res.status = ST_OK;
    if (wd.op == OP_BEGIN) begin
      // begin also restarts an open pass, with no pops reported
      live_clip  = surface_clip();
      nest_level = 0;
      pass_live  = 1'b1;
    end else if (!pass_live) begin
      res.status = ST_INACTIVE;
      inactive_replies++;
    end else if (wd.op == OP_END) begin
      res.pop_count = nest_level[CNT_W-1:0];
      nest_level    = 0;
      live_clip     = surface_clip();
      pass_live     = 1'b0;
    end else if (wd.op == OP_PUSH) begin
      if (nest_level >= NEST_MAX) begin
        res.status = ST_FULL;
        full_refusals++;
      end else begin
        saved_clip[nest_level] = live_clip;
        live_clip = overlap(live_clip, wd.rect);
        nest_level++;
        res.push_emitted = 1'b1;
        if (live_clip.w == 0)
          empty_clips++;
      end
    end else begin
      // pop on an empty stack falls back to the surface
      if (nest_level > 0) begin
        nest_level--;
        live_clip     = saved_clip[nest_level];
        res.pop_count = CNT_W'(1);
      end else begin
        live_clip = surface_clip();
      end
    end
    if (nest_level > deepest)
      deepest = nest_level;
    res.clip      = live_clip;
    res.depth     = nest_level[CNT_W-1:0];
    res.pass_open = pass_live;
    pending_reports.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers words from op_words with a random gap after each one
  // ---------------------------------------------------------------------------
  clip_word_t  drive_word = '0;
  int unsigned send_gap = 0;
  int          words_queued = 0;
  int          words_taken = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  // at least a third of the words go back to back even with idling on
  function automatic int unsigned draw_wait(bit idle_on);
    if (!idle_on || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, IDLE_MAX);
  endfunction

  always @(posedge clk) begin : sender_p
    int unsigned gap;
    logic        offer;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      gap   = send_gap;
      offer = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_clip_op(drive_word);
        words_taken++;
        offer = 1'b0;
        gap   = draw_wait(in_idle_on);
      end
      // valid stays high across back-to-back words, never dropped and raised
      if (!offer) begin
        if (gap > 0) begin
          gap--;
        end else if (op_words.size() > 0) begin
          drive_word = op_words.pop_front();
          offer      = 1'b1;
        end
      end
      in_bus.valid     <= offer;
      in_bus.operation <= drive_word.op;
      in_bus.rect_x    <= drive_word.rect.x;
      in_bus.rect_y    <= drive_word.rect.y;
      in_bus.rect_w    <= drive_word.rect.w;
      in_bus.rect_h    <= drive_word.rect.h;
      send_gap         <= gap;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall after each result, plus rare long hold-offs
  // ---------------------------------------------------------------------------
  int unsigned take_gap = 0;
  int unsigned hold_left = 0;
  int          holds_asked = 0;
  int          holds_given = 0;

  // long hold-off has a counter of its own, started on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (holds_given < holds_asked) begin
      hold_left   <= HOLD_LEN;
      holds_given <= holds_given + 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : receiver_p
    int unsigned gap;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      take_gap      <= 0;
    end else begin
      gap = take_gap;
      if (out_bus.valid && out_bus.ready)
        gap = draw_wait(out_idle_on);
      else if (gap > 0)
        gap--;
      take_gap      <= gap;
      out_bus.ready <= (gap == 0) && (hold_left <= 1);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every result word against the oldest prediction
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int fail_count = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= SHOW_MAX)
      $display("result word %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : checker_p
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("word with nothing predicted, status", out_bus.status, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_bus.status !== want.status)
          flag_mismatch("status", out_bus.status, want.status);
        if (out_bus.push_emitted !== want.push_emitted)
          flag_mismatch("push_emitted", out_bus.push_emitted, want.push_emitted);
        if (out_bus.pop_count !== want.pop_count)
          flag_mismatch("pop_count", out_bus.pop_count, want.pop_count);
        if (out_bus.clip_x !== want.clip.x)
          flag_mismatch("clip_x", int'(out_bus.clip_x), int'(want.clip.x));
        if (out_bus.clip_y !== want.clip.y)
          flag_mismatch("clip_y", int'(out_bus.clip_y), int'(want.clip.y));
        if (out_bus.clip_w !== want.clip.w)
          flag_mismatch("clip_w", out_bus.clip_w, want.clip.w);
        if (out_bus.clip_h !== want.clip.h)
          flag_mismatch("clip_h", out_bus.clip_h, want.clip.h);
        if (out_bus.depth !== want.depth)
          flag_mismatch("depth", out_bus.depth, want.depth);
        if (out_bus.pass_open !== want.pass_open)
          flag_mismatch("pass_open", out_bus.pass_open, want.pass_open);
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("timeout at cycle %0d with %0d result words outstanding",
               cycle_count, pending_reports.size());
      $display("[clip_rect_stack] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(input op_t op, input rect_t r);
    clip_word_t wd;
    wd.op   = op;
    wd.rect = r;
    op_words.push_back(wd);
    words_queued++;
  endtask

  // coordinates cluster around the surface so overlaps are partial, with
  // full-range and extreme values mixed in
  function automatic logic [15:0] rand_edge(logic [15:0] span);
    case ($urandom_range(0, 7))
      0:       return 16'($urandom());
      1:       return 16'h8000;
      2:       return 16'h7fff;
      default: return 16'($urandom_range(0, span + 8) - span / 4 - 4);
    endcase
  endfunction

  function automatic logic [15:0] rand_size(logic [15:0] span);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, span + 4));
    endcase
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    r.x = rand_edge(surf_w);
    r.y = rand_edge(surf_h);
    r.w = rand_size(surf_w);
    r.h = rand_size(surf_h);
    return r;
  endfunction

  // mostly whole passes: begin, a nested push/pop walk, end; some stray words
  task automatic queue_pass_mix(input int target);
    int first;
    int level;
    int push_bias;
    first = words_queued;
    while (words_queued < first + target) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_word(op_t'($urandom_range(0, 3)), rand_rect());
      end else begin
        queue_word(OP_BEGIN, rand_rect());
        level     = 0;
        push_bias = $urandom_range(4, 8);
        repeat ($urandom_range(1, 24)) begin
          if ($urandom_range(0, 39) == 0) begin
            // restart in the middle of a pass
            queue_word(OP_BEGIN, rand_rect());
            level = 0;
          end else if ($urandom_range(0, 9) < ((level >= NEST_MAX) ? 2 : push_bias)) begin
            queue_word(OP_PUSH, rand_rect());
            if (level < NEST_MAX)
              level++;
          end else begin
            queue_word(OP_POP, rand_rect());
            if (level > 0)
              level--;
          end
        end
        if ($urandom_range(0, 9) != 0)
          queue_word(OP_END, rand_rect());
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SURF_W)
      surf_w = val;
    else
      surf_h = val;
  endtask

  // idle means every word accepted and every result back; the block answers
  // each word, so the wait ends once the last prediction has been matched
  task automatic wait_idle();
    while (words_taken != words_queued || pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : main_p
    logic [15:0] pw, ph;
    int          span;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_BEGIN;
    in_bus.rect_x    = '0;
    in_bus.rect_y    = '0;
    in_bus.rect_w    = '0;
    in_bus.rect_h    = '0;
    out_bus.ready    = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: words outside a pass report the reset clip and change nothing
    queue_word(OP_PUSH, mk_rect(-32768, -32768, 65535, 65535));
    queue_word(OP_POP, mk_rect(32767, 32767, 0, 0));
    queue_word(OP_END, mk_rect(0, 0, 0, 0));
    queue_word(OP_BEGIN, mk_rect(0, 0, 0, 0));
    // huge request covers the surface, partial overlap, disjoint, zero width
    queue_word(OP_PUSH, mk_rect(-32768, -32768, 65535, 65535));
    queue_word(OP_PUSH, mk_rect(100, -10, 50, 300));
    queue_word(OP_PUSH, mk_rect(32767, 32767, 65535, 65535));
    queue_word(OP_PUSH, mk_rect(10, 10, 0, 5));
    queue_word(OP_POP, mk_rect(0, 0, 0, 0));
    queue_word(OP_POP, mk_rect(0, 0, 0, 0));
    // begin while nested, then fill the stack and push once more
    queue_word(OP_BEGIN, mk_rect(0, 0, 0, 0));
    repeat (NEST_MAX) queue_word(OP_PUSH, rand_rect());
    queue_word(OP_PUSH, mk_rect(0, 0, 10, 10));
    queue_word(OP_POP, mk_rect(0, 0, 0, 0));
    queue_word(OP_END, mk_rect(0, 0, 0, 0));
    // pop on an empty stack inside a pass
    queue_word(OP_BEGIN, mk_rect(0, 0, 0, 0));
    queue_word(OP_POP, mk_rect(0, 0, 0, 0));
    wait_idle();

    // random phases, each with its own surface size and one of several idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin pw = 16'd1;     ph = 16'd1;     end
        1:       begin pw = 16'd65535; ph = 16'd65535; end
        2:       begin pw = 16'd640;   ph = 16'd480;   end
        3:       begin pw = 16'd65535; ph = 16'd1;     end
        4:       begin pw = 16'd1;     ph = 16'd65535; end
        5:       begin pw = 16'd0;     ph = 16'd200;   end  // zero-sized surface
        6:       begin pw = 16'd37;    ph = 16'd0;     end
        default: begin pw = 16'd320;   ph = 16'd240;   end
      endcase
      write_reg(CFG_SURF_W, pw);
      write_reg(CFG_SURF_H, ph);
      in_idle_on  = (p % 3 != 1);
      out_idle_on = (p % 4 != 2);
      span = (pw == 0 || ph == 0) ? 60 : 170;
      queue_pass_mix(span);
      // with the sender running flat out, a long hold-off backs up the block
      if (p == 1 || p == 4)
        holds_asked++;
      wait_idle();
    end

    repeat (16) @(posedge clk);
    $display("checked %0d result words from %0d operation words over %0d surface sizes",
             results_seen, words_queued, PHASES + 1);
    $display("deepest nesting %0d, %0d stack-full refusals, %0d inactive replies, %0d empty clips",
             deepest, full_refusals, inactive_replies, empty_clips);
    if (fail_count == 0)
      $display("[clip_rect_stack] OK");
    else
      $display("[clip_rect_stack] ERROR");
    $finish;
  end

endmodule
